@@ rtl/cbd_pkg.sv @@
`timescale 1ns / 1ps

package cbd_pkg;

  // Default number of line slots; one less character of a line is kept
  localparam int unsigned DefLineCapacity = 128;

  localparam int unsigned SizeW = 31;
  localparam logic [SizeW-1:0] SizeLimit = 31'h07FF_FFFF;

  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_AFTER   = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_PROTO  = 2'd2,
    KIND_CLOSED = 2'd3
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] body_byte;
    kind_e      kind;
  } res_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ rtl/chunked_body_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Dir  tdata           tuser        tlast
// s_axis    in   data_byte[7:0]  new_message  end_of_stream
// m_axis    out  body_byte[7:0]  kind[1:0]    -
//
// One word is decoded per cycle: the chunk state updates in a single pass
// from the accepted word, and any result lands in the output register, or in the skid entry when the output is stalled.
// A two-entry output (register plus skid) keeps s_axis_tready registered;
// input stalls only when both entries hold results.
// Reset (rst_ni low, asynchronous) returns the decoder to the size line and
// empties the output. Words that give no result take no output slot.

module chunked_body_decoder #(
  parameter int unsigned LINE_CAPACITY = cbd_pkg::DefLineCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] new_message
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] body_byte
  output logic [1:0] m_axis_tuser_o    // [1:0] kind
);

  cbd_pkg::res_t res;
  cbd_pkg::res_t out_q, out_d;
  cbd_pkg::res_t skid_q, skid_d;
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  logic          in_acc;
  logic          out_fire;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  cbd_core #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (in_acc),
    .data_byte_i     (s_axis_tdata_i),
    .end_of_stream_i (s_axis_tlast_i),
    .new_message_i   (s_axis_tuser_i),
    .res_o           (res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      // drain the skid word into the output register
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_fire) begin
      out_d       = res;
      out_valid_d = res.valid;
    end else if (res.valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.body_byte;
  assign m_axis_tuser_o  = out_q.kind;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && m_axis_tready_i |=> !skid_valid_q && out_valid_q)
    else $error("skid word not moved on output handshake");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && out_valid_q && !m_axis_tready_i |=> skid_valid_q)
    else $error("result dropped while output stalled");

endmodule

@@ rtl/cbd_core.sv @@
`timescale 1ns / 1ps

module cbd_core #(
  parameter int unsigned LINE_CAPACITY = cbd_pkg::DefLineCapacity
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_stream_i,
  input  logic           new_message_i,
  output cbd_pkg::res_t  res_o
);

  localparam int unsigned LenW = $clog2(LINE_CAPACITY);
  localparam int unsigned SizeW = cbd_pkg::SizeW;

  cbd_pkg::phase_e   phase_q, phase_d;
  logic [SizeW-1:0]  size_value_q, size_value_d;
  logic [SizeW-1:0]  bytes_left_q, bytes_left_d;
  logic [LenW-1:0]   line_length_q, line_length_d;
  logic              digit_seen_q, digit_seen_d;
  logic              hex_stopped_q, hex_stopped_d;
  logic              size_ovf_q, size_ovf_d;

  always_comb begin
    cbd_pkg::phase_e  ph;
    logic [SizeW-1:0] sz;
    logic [SizeW-1:0] bl;
    logic [SizeW-1:0] bl_dec;
    logic [LenW-1:0]  len;
    logic             dig;
    logic             hst;
    logic             ovf;
    logic [4:0]       hx;
    logic             clear;
    logic             bad_size;

    // new_message restarts the decoder before the word is handled
    if (acc_i && new_message_i) begin
      ph  = cbd_pkg::PH_SIZE;
      sz  = '0;
      bl  = '0;
      len = '0;
      dig = 1'b0;
      hst = 1'b0;
      ovf = 1'b0;
    end else begin
      ph  = phase_q;
      sz  = size_value_q;
      bl  = bytes_left_q;
      len = line_length_q;
      dig = digit_seen_q;
      hst = hex_stopped_q;
      ovf = size_ovf_q;
    end

    phase_d       = ph;
    size_value_d  = sz;
    bytes_left_d  = bl;
    line_length_d = len;
    digit_seen_d  = dig;
    hex_stopped_d = hst;
    size_ovf_d    = ovf;

    res_o.valid     = 1'b0;
    res_o.body_byte = '0;
    res_o.kind      = cbd_pkg::KIND_BYTE;

    bl_dec   = bl - SizeW'(1);
    hx       = cbd_pkg::hex_digit(data_byte_i);
    bad_size = ovf || !dig;
    clear    = 1'b0;

    if (acc_i && ph != cbd_pkg::PH_DONE) begin
      if (end_of_stream_i) begin
        res_o.valid = 1'b1;
        phase_d     = cbd_pkg::PH_DONE;
        if (ph == cbd_pkg::PH_TRAILER) begin
          res_o.kind = cbd_pkg::KIND_OK;
        end else if (ph != cbd_pkg::PH_SIZE || len == '0) begin
          res_o.kind = cbd_pkg::KIND_CLOSED;
        end else if (bad_size) begin
          res_o.kind = cbd_pkg::KIND_PROTO;
        end else if (sz == '0) begin
          res_o.kind = cbd_pkg::KIND_OK;
        end else begin
          res_o.kind = cbd_pkg::KIND_CLOSED;
        end
      end else if (ph == cbd_pkg::PH_DATA) begin
        bytes_left_d    = bl_dec;
        res_o.valid     = 1'b1;
        res_o.body_byte = data_byte_i;
        if (bl_dec == '0) begin
          phase_d = cbd_pkg::PH_AFTER;
          clear   = 1'b1;
        end
      end else if (data_byte_i == cbd_pkg::CharLf) begin
        clear = 1'b1;
        case (ph)
          cbd_pkg::PH_SIZE: begin
            if (bad_size) begin
              res_o.valid = 1'b1;
              res_o.kind  = cbd_pkg::KIND_PROTO;
              phase_d     = cbd_pkg::PH_DONE;
              clear       = 1'b0;
            end else if (sz == '0) begin
              phase_d = cbd_pkg::PH_TRAILER;
            end else begin
              phase_d      = cbd_pkg::PH_DATA;
              bytes_left_d = sz;
            end
          end
          cbd_pkg::PH_AFTER: begin
            phase_d = cbd_pkg::PH_SIZE;
          end
          default: begin
            // empty trailer line closes the message
            if (len == '0) begin
              res_o.valid = 1'b1;
              res_o.kind  = cbd_pkg::KIND_OK;
              phase_d     = cbd_pkg::PH_DONE;
              clear       = 1'b0;
            end
          end
        endcase
      end else if (data_byte_i != cbd_pkg::CharCr &&
                   ({1'b0, len} + (LenW+1)'(1)) < (LenW+1)'(LINE_CAPACITY)) begin
        line_length_d = len + LenW'(1);
        if (ph == cbd_pkg::PH_SIZE && !hst) begin
          if (!hx[4]) begin
            hex_stopped_d = 1'b1;
          end else if (sz > cbd_pkg::SizeLimit) begin
            size_ovf_d    = 1'b1;
            hex_stopped_d = 1'b1;
          end else begin
            size_value_d = {sz[SizeW-5:0], hx[3:0]};
            digit_seen_d = 1'b1;
          end
        end
      end
    end

    if (clear) begin
      line_length_d = '0;
      digit_seen_d  = 1'b0;
      hex_stopped_d = 1'b0;
      size_ovf_d    = 1'b0;
      size_value_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= cbd_pkg::PH_SIZE;
      size_value_q  <= '0;
      bytes_left_q  <= '0;
      line_length_q <= '0;
      digit_seen_q  <= 1'b0;
      hex_stopped_q <= 1'b0;
      size_ovf_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      size_value_q  <= size_value_d;
      bytes_left_q  <= bytes_left_d;
      line_length_q <= line_length_d;
      digit_seen_q  <= digit_seen_d;
      hex_stopped_q <= hex_stopped_d;
      size_ovf_q    <= size_ovf_d;
    end
  end

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DATA |-> bytes_left_q != '0)
    else $error("chunk data phase with no bytes left");

  a_terminal_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind != cbd_pkg::KIND_BYTE |=> phase_q == cbd_pkg::PH_DONE)
    else $error("terminal result did not finish the message");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DONE && !new_message_i |-> !res_o.valid)
    else $error("result after terminal result");

  a_clear_after_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cbd_pkg::PH_DATA && phase_d == cbd_pkg::PH_AFTER |=> line_length_q == '0)
    else $error("line not cleared after chunk data");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LineCap     = cbd_pkg::DefLineCapacity;
  localparam int unsigned RandomWords = 240;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 300000;

  typedef struct {
    logic [7:0] c;
    bit         eos;
    bit         nm;
  } in_word_t;

  typedef struct {
    logic [7:0]     b;
    cbd_pkg::kind_e k;
  } out_word_t;

  logic       clk;
  logic       rst_n;
  logic       s_valid;
  logic       s_ready;
  logic [7:0] s_data;
  logic       s_user;
  logic       s_last;
  logic       m_valid;
  logic       m_ready;
  logic [7:0] m_data;
  logic [1:0] m_user;

  chunked_body_decoder dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // Decoder state as the block should hold it
  cbd_pkg::phase_e dec_phase;
  logic [30:0]     dec_size;
  logic [30:0]     dec_left;
  int              dec_line_len;
  bit              dec_digits;
  bit              dec_hex_done;
  bit              dec_overflow;

  out_word_t   expected_words[$];
  in_word_t    msg_q[$];
  bit          next_nm;

  int unsigned errors;
  int unsigned live_words;
  int unsigned cycles;
  bit          no_idle;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_size_line();
    dec_line_len = 0;
    dec_digits   = 1'b0;
    dec_hex_done = 1'b0;
    dec_overflow = 1'b0;
    dec_size     = '0;
  endfunction

  function automatic void restart_decoder();
    dec_phase = cbd_pkg::PH_SIZE;
    dec_left  = '0;
    clear_size_line();
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    logic [7:0] lc;
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    // fold upper case onto lower case; digits were handled above
    lc = c | 8'h20;
    if (lc >= 8'h61 && lc <= 8'h66) return int'(lc - 8'h61) + 10;
    return -1;
  endfunction

  // Advance the decoder by one word; returns 1 when the word yields a result
  function automatic bit decode_word(input in_word_t it, output out_word_t res);
    int v;
    res.b = 8'h00;
    res.k = cbd_pkg::KIND_BYTE;
    if (it.nm) restart_decoder();
    if (dec_phase == cbd_pkg::PH_DONE) return 1'b0;

    if (it.eos) begin
      if (dec_phase == cbd_pkg::PH_TRAILER) res.k = cbd_pkg::KIND_OK;
      else if (dec_phase != cbd_pkg::PH_SIZE || dec_line_len == 0) res.k = cbd_pkg::KIND_CLOSED;
      else if (dec_overflow || !dec_digits) res.k = cbd_pkg::KIND_PROTO;
      else if (dec_size == '0) res.k = cbd_pkg::KIND_OK;
      else res.k = cbd_pkg::KIND_CLOSED;
      dec_phase = cbd_pkg::PH_DONE;
      return 1'b1;
    end

    if (dec_phase == cbd_pkg::PH_DATA) begin
      dec_left = dec_left - 31'd1;
      if (dec_left == '0) begin
        dec_phase = cbd_pkg::PH_AFTER;
        clear_size_line();
      end
      res.b = it.c;
      return 1'b1;
    end

    if (it.c == cbd_pkg::CharLf) begin
      if (dec_phase == cbd_pkg::PH_SIZE) begin
        if (dec_overflow || !dec_digits) begin
          res.k = cbd_pkg::KIND_PROTO;
          dec_phase = cbd_pkg::PH_DONE;
          return 1'b1;
        end
        if (dec_size == '0) begin
          dec_phase = cbd_pkg::PH_TRAILER;
        end else begin
          dec_phase = cbd_pkg::PH_DATA;
          dec_left  = dec_size;
        end
      end else if (dec_phase == cbd_pkg::PH_AFTER) begin
        dec_phase = cbd_pkg::PH_SIZE;
      end else if (dec_line_len == 0) begin
        res.k = cbd_pkg::KIND_OK;
        dec_phase = cbd_pkg::PH_DONE;
        return 1'b1;
      end
      clear_size_line();
      return 1'b0;
    end
    if (it.c == cbd_pkg::CharCr) return 1'b0;

    // drop characters past the kept length
    if (dec_line_len + 1 >= LineCap) return 1'b0;
    dec_line_len++;

    if (dec_phase == cbd_pkg::PH_SIZE && !dec_hex_done) begin
      v = hex_val(it.c);
      if (v < 0) begin
        dec_hex_done = 1'b1;
      end else if (dec_size > cbd_pkg::SizeLimit) begin
        dec_overflow = 1'b1;
        dec_hex_done = 1'b1;
      end else begin
        dec_size = {dec_size[26:0], 4'(v)};
        dec_digits = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic send_word(input in_word_t it);
    out_word_t res;
    s_valid <= 1'b1;
    s_data  <= it.c;
    s_last  <= it.eos;
    s_user  <= it.nm;
    do @(posedge clk); while (!s_ready);
    if (it.nm || dec_phase != cbd_pkg::PH_DONE) live_words++;
    if (decode_word(it, res)) expected_words.push_back(res);
    if (!no_idle && !tx_calm && $urandom_range(0, 11) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_word(msg_q[i]);
  endtask

  task automatic start_message(input bit restart);
    msg_q.delete();
    next_nm = restart;
  endtask

  task automatic put_item(input logic [7:0] c, input bit eos);
    in_word_t it;
    it.c   = c;
    it.eos = eos;
    it.nm  = next_nm;
    next_nm = 1'b0;
    msg_q.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == cbd_pkg::CharLf);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic end_line();
    case ($urandom_range(0, 5))
      0: put_item(cbd_pkg::CharLf, 1'b0);
      1: begin
        put_item(cbd_pkg::CharCr, 1'b0);
        put_item(cbd_pkg::CharCr, 1'b0);
        put_item(cbd_pkg::CharLf, 1'b0);
      end
      default: begin
        put_item(cbd_pkg::CharCr, 1'b0);
        put_item(cbd_pkg::CharLf, 1'b0);
      end
    endcase
  endtask

  task automatic put_size_line(input logic [31:0] value);
    int top;
    bit upper;
    upper = 1'($urandom_range(0, 1));
    repeat ($urandom_range(0, 2)) put_item(8'h30, 1'b0);
    top = 0;
    for (int i = 7; i > 0; i--) begin
      if (top == 0 && value[4*i +: 4] != 4'd0) top = i;
    end
    for (int i = top; i >= 0; i--) put_item(hex_char(value[4*i +: 4], upper), 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      put_item(8'h3B, 1'b0);
      repeat ($urandom_range(0, 4)) put_item(text_byte(), 1'b0);
    end
    end_line();
  endtask

  task automatic put_trailer_line();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(126, 140)) put_item(text_byte(), 1'b0);
    end else begin
      repeat ($urandom_range(1, 10)) put_item(text_byte(), 1'b0);
    end
    end_line();
  endtask

  // Mostly well-formed chunked bodies with random content; some broken or cut
  task automatic build_message();
    int chunks;
    int shape;
    int zeros;
    int cut;
    logic [31:0] sz;
    start_message($urandom_range(0, 9) != 0);
    chunks = $urandom_range(0, 3);
    for (int k = 0; k < chunks; k++) begin
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
        // size line without digits
        put_item($urandom_range(0, 1) ? 8'h3B : 8'h67, 1'b0);
        end_line();
        return;
      end
      if (shape == 1) begin
        // too many digits; may also be a huge but legal size
        put_item(hex_char(4'($urandom_range(1, 15)), 1'b1), 1'b0);
        repeat ($urandom_range(7, 9)) put_item(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b0);
        end_line();
        repeat ($urandom_range(0, 5)) put_item(8'($urandom_range(0, 255)), 1'b0);
        put_item(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      if (shape == 2) begin
        // long size line; the digit may fall past the kept length
        zeros = $urandom_range(110, 130);
        sz = 32'($urandom_range(1, 15));
        repeat (zeros) put_item(8'h30, 1'b0);
        put_item(hex_char(sz[3:0], 1'b1), 1'b0);
        repeat ($urandom_range(0, 12)) put_item(8'h78, 1'b0);
        end_line();
      end else begin
        sz = ($urandom_range(0, 5) == 0) ? 32'($urandom_range(9, 40)) : 32'($urandom_range(1, 8));
        put_size_line(sz);
      end
      repeat (sz) put_item(8'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) put_item(text_byte(), 1'b0);
      end
      end_line();
    end
    put_size_line(32'd0);
    repeat ($urandom_range(0, 2)) put_trailer_line();
    end_line();
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
      put_item(8'($urandom_range(0, 255)), 1'b1);
    end else if ($urandom_range(0, 9) == 0) begin
      // end mark after the body is complete: ignored
      put_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic send_noise();
    in_word_t it;
    repeat ($urandom_range(1, 10)) begin
      it.c   = 8'($urandom_range(0, 255));
      it.eos = ($urandom_range(0, 7) == 0);
      it.nm  = ($urandom_range(0, 9) == 0);
      send_word(it);
    end
  endtask

  task automatic eos_case(input string s);
    start_message(1'b1);
    put_text(s);
    put_item(8'($urandom_range(0, 255)), 1'b1);
    send_message();
  endtask

  task automatic test_basic_body();
    start_message(1'b1);
    put_text("1;e\015\n");
    put_item(cbd_pkg::CharCr, 1'b0);
    put_text("\015\n0\015\nt\n\n");
    send_message();
  endtask

  task automatic test_line_ends_and_closes();
    eos_case("");
    eos_case("B");
    eos_case("0");
    eos_case("x");
    eos_case("0\n");
    eos_case("1\n");
    eos_case("1\nz");
    start_message(1'b1);
    put_text("\n");
    send_message();
    // finished: ignored without a restart
    start_message(1'b0);
    put_item(8'hFF, 1'b0);
    send_message();
  endtask

  task automatic test_random_bodies();
    int unsigned target;
    target = live_words + RandomWords;
    while (live_words < target) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 11) == 0) begin
        send_noise();
      end else begin
        build_message();
        send_message();
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_output_backpressure();
    tx_calm = 1'b1;
    hold_req = 1'b1;
    start_message(1'b1);
    put_text("40\015\n");
    repeat (64) put_item(8'($urandom_range(0, 255)), 1'b0);
    put_text("\015\n0\015\n\015\n");
    send_message();
    if (hold_req) begin
      // hold the input idle until the long receiver stall ends
      s_valid <= 1'b0;
      while (hold_req) @(posedge clk);
    end
    tx_calm = 1'b0;
  endtask

  task automatic test_steady_stream();
    no_idle = 1'b1;
    repeat (3) begin
      build_message();
      send_message();
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin : rx_side
    int hold_cnt;
    m_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && !rx_calm && $urandom_range(0, 9) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_words.size() == 0) begin
        if (errors < 10) $display("unexpected word: byte %02h kind %0d", m_data, m_user);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (m_data !== want.b || m_user !== want.k) begin
          if (errors < 10) begin
            $display("mismatch: expected byte %02h kind %0d, got byte %02h kind %0d",
                     want.b, want.k, m_data, m_user);
          end
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    s_valid  = 1'b0;
    s_data   = 8'h00;
    s_user   = 1'b0;
    s_last   = 1'b0;
    rst_n    = 1'b0;
    errors   = 0;
    no_idle  = 1'b0;
    tx_calm  = 1'b0;
    rx_calm  = 1'b0;
    hold_req = 1'b0;
    next_nm  = 1'b0;
    restart_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_body();
    test_line_ends_and_closes();
    test_random_bodies();
    test_output_backpressure();
    test_steady_stream();

    s_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    errors += expected_words.size();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
